// ----- hw/rtl/h2r_pkg.sv -----
// Shared types, constants and a helper function for the HSV to RGB565 converter.
// No dependencies; every other file of the block refers to this package by scoped names.

package h2r_pkg;

  // Fixed-point format of saturation and brightness (Q1.SCALE_BITS).
  localparam int SCALE_BITS = 12;
  localparam int unsigned ONE_I = 1 << SCALE_BITS;

  // Field widths.
  localparam int IN_W  = 13;
  localparam int OUT_W = 16;
  localparam int V_W   = SCALE_BITS + 1;

  // Hue geometry in 1/16 degree units.
  localparam int unsigned HUE_SEXTANT = 960;
  localparam int unsigned HUE_FULL    = 5760;
  localparam int          SEXTANTS    = 6;
  localparam int          FRAC_W      = 10;

  // A channel term is v * t, where t is at most ONE * HUE_SEXTANT.
  localparam int          T_W    = SCALE_BITS + FRAC_W;
  localparam int unsigned T_FULL = ONE_I * HUE_SEXTANT;
  localparam int          P_W    = V_W + T_W;

  // Scaling by 31 or 63 widens the product by at most six bits.
  localparam int X_W = P_W + 6;

  // The common denominator is 960 * ONE * ONE = 15 * 2^(2 * SCALE_BITS + 6).
  localparam int Q_SHIFT = 2 * SCALE_BITS + 6;
  localparam int Q_W     = 10;

  // floor(q / 15) equals (q * 4370) >> 16 for every q below 960.
  localparam int          RECIP_W     = 13;
  localparam int unsigned RECIP15     = 4370;
  localparam int          RECIP_SHIFT = 16;

  localparam int C_W    = 6;
  localparam int RB_W   = 5;
  localparam int G_W    = 6;

  // Register stages from input transfer to output register.
  localparam int PIPE_DEPTH = 5;

  typedef enum logic [2:0] {
    SEXT_0,
    SEXT_1,
    SEXT_2,
    SEXT_3,
    SEXT_4,
    SEXT_5,
    SEXT_OUT
  } sext_t;

  typedef enum logic [2:0] {
    SRC_V,
    SRC_A,
    SRC_B,
    SRC_C,
    SRC_Z
  } src_t;

  typedef struct packed {
    src_t r;
    src_t g;
    src_t b;
  } src_set_t;

  typedef struct packed {
    logic [V_W-1:0] v;
    logic [T_W-1:0] ta;
    logic [T_W-1:0] tb;
    logic [T_W-1:0] tc;
    src_set_t       src;
  } terms_t;

  // Which term feeds each channel within a sextant.
  function automatic src_set_t sextant_src(sext_t sext);
    src_set_t res;
    case (sext)
      SEXT_0:  res = '{r: SRC_V, g: SRC_C, b: SRC_A};
      SEXT_1:  res = '{r: SRC_B, g: SRC_V, b: SRC_A};
      SEXT_2:  res = '{r: SRC_A, g: SRC_V, b: SRC_C};
      SEXT_3:  res = '{r: SRC_A, g: SRC_B, b: SRC_V};
      SEXT_4:  res = '{r: SRC_C, g: SRC_A, b: SRC_V};
      SEXT_5:  res = '{r: SRC_V, g: SRC_A, b: SRC_B};
      default: res = '{r: SRC_Z, g: SRC_Z, b: SRC_Z};
    endcase
    return res;
  endfunction

endpackage

// ----- hw/rtl/h2r_if.sv -----
// Channel interfaces for the HSV to RGB565 converter: the HSV input and the pixel output.
// Depends on h2r_pkg for the field widths.

interface h2r_in_if;
  logic                     valid;
  logic                     ready;
  logic [h2r_pkg::IN_W-1:0] hue;
  logic [h2r_pkg::IN_W-1:0] saturation;
  logic [h2r_pkg::IN_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface h2r_out_if;
  logic                      valid;
  logic                      ready;
  logic [h2r_pkg::OUT_W-1:0] pixel_rgb565;

  modport source (output valid, output pixel_rgb565, input ready);
  modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

// ----- hw/rtl/h2r_front.sv -----
// Front end of the converter: clamping, sextant decode (stage 1) and the three hue terms
// (stage 2). Depends on h2r_pkg.

module h2r_front (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [h2r_pkg::IN_W-1:0] hue,
  input  logic [h2r_pkg::IN_W-1:0] saturation,
  input  logic [h2r_pkg::IN_W-1:0] brightness,
  output h2r_pkg::terms_t          terms
);

  logic [h2r_pkg::IN_W-1:0]   hue_w;
  h2r_pkg::sext_t             sext;
  logic [h2r_pkg::FRAC_W-1:0] frac;
  logic [h2r_pkg::V_W-1:0]    sat_c;
  logic [h2r_pkg::V_W-1:0]    bri_c;
  h2r_pkg::src_set_t          src;

  logic [h2r_pkg::V_W-1:0]    s1_sat_r;
  logic [h2r_pkg::V_W-1:0]    s1_bri_r;
  logic [h2r_pkg::FRAC_W-1:0] s1_frac_r;
  logic [h2r_pkg::FRAC_W-1:0] s1_fracc_r;
  h2r_pkg::src_set_t          s1_src_r;

  h2r_pkg::terms_t            terms_nxt;
  h2r_pkg::terms_t            terms_r;

  // Stage 1: a full circle wraps to zero; anything beyond it falls in no sextant.
  always_comb begin
    hue_w = (hue == h2r_pkg::IN_W'(h2r_pkg::HUE_FULL)) ? '0 : hue;
    sext  = h2r_pkg::SEXT_OUT;
    frac  = '0;
    for (int k = 0; k < h2r_pkg::SEXTANTS; k++) begin
      if (hue_w >= h2r_pkg::IN_W'(k * h2r_pkg::HUE_SEXTANT) &&
          hue_w <  h2r_pkg::IN_W'((k + 1) * h2r_pkg::HUE_SEXTANT)) begin
        sext = h2r_pkg::sext_t'(3'(k));
        frac = h2r_pkg::FRAC_W'(hue_w - h2r_pkg::IN_W'(k * h2r_pkg::HUE_SEXTANT));
      end
    end

    sat_c = (int'(saturation) > int'(h2r_pkg::ONE_I)) ? h2r_pkg::V_W'(h2r_pkg::ONE_I)
                                                      : h2r_pkg::V_W'(saturation);
    bri_c = (int'(brightness) > int'(h2r_pkg::ONE_I)) ? h2r_pkg::V_W'(h2r_pkg::ONE_I)
                                                      : h2r_pkg::V_W'(brightness);

    // With no saturation every channel is the brightness, whatever the hue.
    if (sat_c == '0) begin
      src = '{r: h2r_pkg::SRC_V, g: h2r_pkg::SRC_V, b: h2r_pkg::SRC_V};
    end else begin
      src = h2r_pkg::sextant_src(sext);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sat_r   <= sat_c;
      s1_bri_r   <= bri_c;
      s1_frac_r  <= frac;
      s1_fracc_r <= h2r_pkg::FRAC_W'(h2r_pkg::HUE_SEXTANT) - frac;
      s1_src_r   <= src;
    end
  end

  // Stage 2: aa, bb and cc without the common factor v.
  always_comb begin
    terms_nxt.v   = s1_bri_r;
    terms_nxt.ta  = h2r_pkg::T_W'((h2r_pkg::T_W'(h2r_pkg::ONE_I) - h2r_pkg::T_W'(s1_sat_r)) *
                                  h2r_pkg::T_W'(h2r_pkg::HUE_SEXTANT));
    terms_nxt.tb  = h2r_pkg::T_W'(h2r_pkg::T_FULL) -
                    h2r_pkg::T_W'(h2r_pkg::T_W'(s1_sat_r) * h2r_pkg::T_W'(s1_frac_r));
    terms_nxt.tc  = h2r_pkg::T_W'(h2r_pkg::T_FULL) -
                    h2r_pkg::T_W'(h2r_pkg::T_W'(s1_sat_r) * h2r_pkg::T_W'(s1_fracc_r));
    terms_nxt.src = s1_src_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

// ----- hw/rtl/h2r_chan.sv -----
// One colour channel of the converter: term selection and product (stage 3), scaling by
// 31 or 63 with the power-of-two part of the division (stage 4), division by 15 (stage 5).
// Depends on h2r_pkg.

module h2r_chan (
  input  logic                    clk,
  input  logic                    adv,
  input  logic                    green,
  input  logic [h2r_pkg::V_W-1:0] v,
  input  logic [h2r_pkg::T_W-1:0] ta,
  input  logic [h2r_pkg::T_W-1:0] tb,
  input  logic [h2r_pkg::T_W-1:0] tc,
  input  h2r_pkg::src_t           src,
  output logic [h2r_pkg::C_W-1:0] level
);

  logic [h2r_pkg::T_W-1:0]                  t_sel;
  logic [h2r_pkg::P_W-1:0]                  prod_nxt;
  logic [h2r_pkg::P_W-1:0]                  prod_r;
  logic [h2r_pkg::X_W-1:0]                  scaled;
  logic [h2r_pkg::Q_W-1:0]                  quot_nxt;
  logic [h2r_pkg::Q_W-1:0]                  quot_r;
  logic [h2r_pkg::Q_W+h2r_pkg::RECIP_W-1:0] recip_prod;
  logic [h2r_pkg::C_W-1:0]                  level_nxt;
  logic [h2r_pkg::C_W-1:0]                  level_r;

  always_comb begin
    case (src)
      h2r_pkg::SRC_V: t_sel = h2r_pkg::T_W'(h2r_pkg::T_FULL);
      h2r_pkg::SRC_A: t_sel = ta;
      h2r_pkg::SRC_B: t_sel = tb;
      h2r_pkg::SRC_C: t_sel = tc;
      default:        t_sel = '0;
    endcase
    prod_nxt = h2r_pkg::P_W'(v) * h2r_pkg::P_W'(t_sel);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  // Multiplying by 2^n - 1 is a shift and a subtract.
  always_comb begin
    if (green) begin
      scaled = (h2r_pkg::X_W'(prod_r) << 6) - h2r_pkg::X_W'(prod_r);
    end else begin
      scaled = (h2r_pkg::X_W'(prod_r) << 5) - h2r_pkg::X_W'(prod_r);
    end
    quot_nxt = h2r_pkg::Q_W'(scaled >> h2r_pkg::Q_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot_r <= quot_nxt;
    end
  end

  always_comb begin
    recip_prod = (h2r_pkg::Q_W + h2r_pkg::RECIP_W)'(quot_r) *
                 (h2r_pkg::Q_W + h2r_pkg::RECIP_W)'(h2r_pkg::RECIP15);
    level_nxt  = h2r_pkg::C_W'(recip_prod >> h2r_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

// ----- hw/rtl/hsv_to_rgb565_converter.sv -----
// Top level of the HSV to RGB565 converter: pipeline control, the front end and three
// channel units. Depends on h2r_pkg, h2r_if, h2r_front and h2r_chan.
//
//   Port     Direction  Payload                           Handshake
//   in_ch    sink       hue, saturation, brightness       valid / ready
//   out_ch   source     pixel_rgb565                      valid / ready
//
// Five register stages; one pixel per clock is accepted and delivered when the output is
// not stalled. Each pixel passes the stage 1 and terms registers of the front end and the
// product, quotient and level registers of the channel units before out_ch presents it.
// The last stage is the output register; the whole pipeline holds while it is full and
// not taken, so in_ch.ready follows !out_ch.valid || out_ch.ready.
// Reset clears the valid bits of all stages; the data registers are not reset.

module hsv_to_rgb565_converter (
  input  logic      clk,
  input  logic      rst_n,
  h2r_in_if.sink    in_ch,
  h2r_out_if.source out_ch
);

  logic [h2r_pkg::PIPE_DEPTH-1:0] vld_r;
  logic [h2r_pkg::PIPE_DEPTH-1:0] vld_nxt;
  logic                           adv;
  h2r_pkg::terms_t                terms;
  logic [h2r_pkg::C_W-1:0]        red_lvl;
  logic [h2r_pkg::C_W-1:0]        grn_lvl;
  logic [h2r_pkg::C_W-1:0]        blu_lvl;

  assign adv         = !vld_r[h2r_pkg::PIPE_DEPTH-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    if (adv) begin
      vld_nxt = {vld_r[h2r_pkg::PIPE_DEPTH-2:0], in_ch.valid};
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  h2r_front u_front (
    .clk        (clk),
    .adv        (adv),
    .hue        (in_ch.hue),
    .saturation (in_ch.saturation),
    .brightness (in_ch.brightness),
    .terms      (terms)
  );

  h2r_chan u_red (
    .clk   (clk),
    .adv   (adv),
    .green (1'b0),
    .v     (terms.v),
    .ta    (terms.ta),
    .tb    (terms.tb),
    .tc    (terms.tc),
    .src   (terms.src.r),
    .level (red_lvl)
  );

  h2r_chan u_grn (
    .clk   (clk),
    .adv   (adv),
    .green (1'b1),
    .v     (terms.v),
    .ta    (terms.ta),
    .tb    (terms.tb),
    .tc    (terms.tc),
    .src   (terms.src.g),
    .level (grn_lvl)
  );

  h2r_chan u_blu (
    .clk   (clk),
    .adv   (adv),
    .green (1'b0),
    .v     (terms.v),
    .ta    (terms.ta),
    .tb    (terms.tb),
    .tc    (terms.tc),
    .src   (terms.src.b),
    .level (blu_lvl)
  );

  assign out_ch.valid        = vld_r[h2r_pkg::PIPE_DEPTH-1];
  assign out_ch.pixel_rgb565 = {red_lvl[h2r_pkg::RB_W-1:0], grn_lvl[h2r_pkg::G_W-1:0],
                                blu_lvl[h2r_pkg::RB_W-1:0]};

  // Reset empties every stage by the next edge.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

  // A stall freezes the occupancy of every stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r == $past(vld_r))
    else $error("stage occupancy changed during a stall");

  // When the pipeline advances, each stage takes over the item of the stage before it.
  a_advance_shifts: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vld_r[h2r_pkg::PIPE_DEPTH-1:1] == $past(vld_r[h2r_pkg::PIPE_DEPTH-2:0]))
    else $error("item lost or repeated between stages");

  // An accepted input always occupies the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted transfer did not enter the pipeline");

endmodule
